### rtl/core/sst_pkg.sv
package sst_pkg;

    localparam int STACK_DEPTH_DEF = 64;

    localparam int VALUE_W = 32;
    localparam int KIND_W  = 8;
    localparam int TAG_W   = 64;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int DEPTH_W = 7;

    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP   = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd3;
    localparam logic [OP_W-1:0] OP_SORT  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [KIND_W-1:0]         kind;
        logic [TAG_W-1:0]          tag;
    } t_rec;

endpackage

### rtl/core/sortable_stack.sv
// Bounded LIFO stack of records (signed value, kind, tag) with an in-place sort.
// Input channel: i_in_valid / o_in_stall with the fields i_op, i_item_value,
// i_item_kind and i_item_tag. An item is taken at a clock edge with valid high
// and stall low. Output channel: o_out_valid / i_out_stall, one result per item.
// Push, clear and unknown op codes load their result into the output register
// at the edge that accepts them, and such items can follow back to back, one
// per cycle, while the receiver keeps up. Pop and peek first read the record
// memory into a read register and load the result from it in state S_READ, so
// the next item is taken no earlier than the return to S_IDLE.
// Sort is a stable insertion sort over the single read port and single write
// port of the record memory: it fetches each key (S_KEY), compares it with the
// entries below in turn (S_CMP), writes it at the bottom when it settles there
// (S_PLACE), and the block accepts no new item until it is done.
// While a result waits in the output register and the receiver stalls, no
// new item is accepted; a result is held unchanged until taken.
// Reset clears the fill count and the control state; the record memory is not
// cleared, since no entry above the fill count is ever read.
module sortable_stack #(
    parameter int STACK_DEPTH = sst_pkg::STACK_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [sst_pkg::OP_W-1:0]         i_op,
    input  logic signed [sst_pkg::VALUE_W-1:0] i_item_value,
    input  logic [sst_pkg::KIND_W-1:0]       i_item_kind,
    input  logic [sst_pkg::TAG_W-1:0]        i_item_tag,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [sst_pkg::STAT_W-1:0]       o_status,
    output logic signed [sst_pkg::VALUE_W-1:0] o_out_value,
    output logic [sst_pkg::KIND_W-1:0]       o_out_kind,
    output logic [sst_pkg::TAG_W-1:0]        o_out_tag,
    output logic [sst_pkg::DEPTH_W-1:0]      o_depth_now
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_KEY,
        S_CMP,
        S_PLACE
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    sst_pkg::t_rec r_key, n_key;
    sst_pkg::t_rec r_rd;
    sst_pkg::t_rec r_mem [STACK_DEPTH];

    logic r_out_valid, n_out_valid;
    logic [sst_pkg::STAT_W-1:0] r_status;
    sst_pkg::t_rec r_out_rec;
    logic [sst_pkg::DEPTH_W-1:0] r_depth;

    logic w_acc;
    logic w_we, w_re, w_ld;
    logic [AW-1:0] w_wa, w_ra;
    sst_pkg::t_rec w_wd, w_item, w_rec;
    logic [sst_pkg::STAT_W-1:0] w_st;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_item     = '{value: i_item_value, kind: i_item_kind, tag: i_item_tag};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_key       = r_key;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_wa        = '0;
        w_wd        = w_item;
        w_re        = 1'b0;
        w_ra        = '0;
        w_ld        = 1'b0;
        w_st        = sst_pkg::ST_OK;
        w_rec       = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_op)
                        sst_pkg::OP_PUSH: begin
                            w_ld = 1'b1;
                            if (r_count == CW'(STACK_DEPTH)) begin
                                w_st = sst_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_wa    = AW'(r_count);
                                n_count = r_count + 1'b1;
                            end
                        end
                        sst_pkg::OP_POP, sst_pkg::OP_PEEK: begin
                            if (r_count == '0) begin
                                w_ld = 1'b1;
                                w_st = sst_pkg::ST_EMPTY;
                            end else begin
                                w_re    = 1'b1;
                                w_ra    = AW'(r_count - 1'b1);
                                n_state = S_READ;
                                if (i_op == sst_pkg::OP_POP) begin
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        sst_pkg::OP_CLEAR: begin
                            w_ld    = 1'b1;
                            n_count = '0;
                        end
                        sst_pkg::OP_SORT: begin
                            if (r_count < CW'(2)) begin
                                w_ld = 1'b1;
                            end else begin
                                w_re    = 1'b1;
                                w_ra    = AW'(1);
                                n_i     = AW'(1);
                                n_state = S_KEY;
                            end
                        end
                        default: begin
                            w_ld = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                w_rec   = r_rd;
                w_ld    = 1'b1;
                n_state = S_IDLE;
            end
            S_KEY: begin
                n_key   = r_rd;
                n_j     = r_i;
                w_re    = 1'b1;
                w_ra    = r_i - 1'b1;
                n_state = S_CMP;
            end
            S_CMP, S_PLACE: begin
                w_we = 1'b1;
                w_wa = r_j;
                if (r_state == S_CMP && $signed(r_rd.value) < $signed(r_key.value)) begin
                    // The entry below is smaller, so it moves up one place.
                    w_wd = r_rd;
                    n_j  = r_j - 1'b1;
                    if (r_j == AW'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        w_re = 1'b1;
                        w_ra = r_j - AW'(2);
                    end
                end else begin
                    w_wd = r_key;
                    if (CW'(r_i) + 1'b1 == r_count) begin
                        w_ld    = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        w_re    = 1'b1;
                        w_ra    = r_i + 1'b1;
                        n_state = S_KEY;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_ld) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_i   <= n_i;
        r_j   <= n_j;
        r_key <= n_key;
        if (w_ld) begin
            r_status  <= w_st;
            r_out_rec <= w_rec;
            r_depth   <= sst_pkg::DEPTH_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd <= r_mem[w_ra];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_value = r_out_rec.value;
    assign o_out_kind  = r_out_rec.kind;
    assign o_out_tag   = r_out_rec.tag;
    assign o_depth_now = r_depth;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("fill count exceeds stack depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_op == sst_pkg::OP_PUSH && r_count != CW'(STACK_DEPTH))
        |=> (r_count == $past(r_count) + 1'b1) && o_out_valid)
        else $error("accepted push did not add a record");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == sst_pkg::ST_EMPTY)
        |-> (o_out_value == '0 && o_out_tag == '0 && o_depth_now == '0))
        else $error("empty error carries a record");

    a_sort_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP || r_state == S_PLACE) |-> (r_j <= r_i && CW'(r_i) < r_count))
        else $error("sort indexes out of order");

endmodule
